// ===== sv/kef_pkg.sv =====
package kef_pkg;

  // Ring of key events; one slot always stays unused
  localparam int QUEUE_SLOTS = 64;
  localparam int PTR_W       = $clog2(QUEUE_SLOTS);
  localparam int CHAR_W      = 7;

  // Command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);

  // Input codes
  localparam logic        OP_PUSH    = 1'b0;
  localparam logic        OP_POP     = 1'b1;
  localparam logic [15:0] EV_KEY     = 16'd1;
  localparam logic [31:0] VAL_PRESS  = 32'd1;
  localparam logic [31:0] VAL_REPEAT = 32'd2;

  // Key codes with a character
  localparam logic [15:0] KEY_SPACE     = 16'd57;
  localparam logic [15:0] KEY_ENTER     = 16'd28;
  localparam logic [15:0] KEY_BACKSPACE = 16'd14;
  localparam logic [15:0] ROW_DIGITS_LO = 16'd2;
  localparam logic [15:0] ROW_TOP_LO    = 16'd16;
  localparam logic [15:0] ROW_HOME_LO   = 16'd30;
  localparam logic [15:0] ROW_BOTTOM_LO = 16'd44;

  localparam logic [CHAR_W-1:0] CH_NONE      = 7'h00;
  localparam logic [CHAR_W-1:0] CH_SPACE     = 7'h20;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 7'h0A;
  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 7'h08;

  // "1234567890"
  localparam logic [CHAR_W-1:0] ROW_DIGITS [10] = '{
    7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37, 7'h38, 7'h39, 7'h30
  };
  // "qwertyuiop"
  localparam logic [CHAR_W-1:0] ROW_TOP [10] = '{
    7'h71, 7'h77, 7'h65, 7'h72, 7'h74, 7'h79, 7'h75, 7'h69, 7'h6F, 7'h70
  };
  // "asdfghjkl"
  localparam logic [CHAR_W-1:0] ROW_HOME [9] = '{
    7'h61, 7'h73, 7'h64, 7'h66, 7'h67, 7'h68, 7'h6A, 7'h6B, 7'h6C
  };
  // "zxcvbnm"
  localparam logic [CHAR_W-1:0] ROW_BOTTOM [7] = '{
    7'h7A, 7'h78, 7'h63, 7'h76, 7'h62, 7'h6E, 7'h6D
  };

  typedef enum logic [1:0] {
    CMD_PUSH_KEY,
    CMD_PUSH_OTHER,
    CMD_POP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [CHAR_W-1:0] ch;
  } cmd_t;

  // Map a key code to its character, CH_NONE when it has none
  function automatic logic [CHAR_W-1:0] code_to_char(input logic [15:0] code);
    logic [15:0]       off_digits;
    logic [15:0]       off_top;
    logic [15:0]       off_home;
    logic [15:0]       off_bottom;
    logic [CHAR_W-1:0] ch;
    off_digits = code - ROW_DIGITS_LO;
    off_top    = code - ROW_TOP_LO;
    off_home   = code - ROW_HOME_LO;
    off_bottom = code - ROW_BOTTOM_LO;
    case (code) inside
      [16'd2:16'd11]:  ch = ROW_DIGITS[off_digits[3:0]];
      [16'd16:16'd25]: ch = ROW_TOP[off_top[3:0]];
      [16'd30:16'd38]: ch = ROW_HOME[off_home[3:0]];
      [16'd44:16'd50]: ch = ROW_BOTTOM[off_bottom[2:0]];
      KEY_SPACE:       ch = CH_SPACE;
      KEY_ENTER:       ch = CH_NEWLINE;
      KEY_BACKSPACE:   ch = CH_BACKSPACE;
      default:         ch = CH_NONE;
    endcase
    return ch;
  endfunction

endpackage

// ===== sv/key_event_fifo_with_ascii_map.sv =====
// Keyboard event queue. Push beats (op 0) offer an input event; key events (type 1) are
// reduced to their ASCII character on entry (press or repeat of a digit, lowercase letter,
// space, enter or backspace key; otherwise "no character") and kept in a ring of
// QUEUE_SLOTS entries, of which QUEUE_SLOTS-1 can be filled; a key event offered to a full
// ring is dropped and flagged. Pop beats (op 1) remove the oldest event. Every input beat
// gives exactly one result beat, in order. A two-entry command queue separates the
// classifying front end from the ring controller, so input stalls and output stalls are
// decoupled. A push result is registered when the ring controller takes its command; a pop
// of a non-empty ring first goes through the S_READ state, the registered read of the ring
// memory. The controller completes one push per cycle while the result register is free and
// takes no new command in S_READ. No clearing pass is needed after reset.
module key_event_fifo_with_ascii_map
  import kef_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              op,
  input  logic [15:0]       event_type,
  input  logic [15:0]       key_code,
  input  logic [31:0]       key_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              stored,
  output logic              dropped_full,
  output logic              had_event,
  output logic              char_valid,
  output logic [CHAR_W-1:0] char_out
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic b_valid;
  logic b_ready;
  cmd_t b_cmd;

  kef_front u_front (
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .event_type (event_type),
    .key_code   (key_code),
    .key_value  (key_value),
    .cmd_valid  (f_valid),
    .cmd_ready  (f_ready),
    .cmd        (f_cmd)
  );

  kef_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (b_valid),
    .pop_ready  (b_ready),
    .pop_cmd    (b_cmd)
  );

  kef_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (b_valid),
    .cmd_ready    (b_ready),
    .cmd          (b_cmd),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stored       (stored),
    .dropped_full (dropped_full),
    .had_event    (had_event),
    .char_valid   (char_valid),
    .char_out     (char_out)
  );

endmodule

// ===== sv/kef_ram.sv =====
module kef_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/kef_front.sv =====
module kef_front
  import kef_pkg::*;
(
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        op,
  input  logic [15:0] event_type,
  input  logic [15:0] key_code,
  input  logic [31:0] key_value,
  output logic        cmd_valid,
  input  logic        cmd_ready,
  output cmd_t        cmd
);

  logic is_press;

  // Accept a beat whenever the command queue has room
  assign in_ready  = cmd_ready;
  assign cmd_valid = in_valid;

  // Classify the beat and reduce a key event to its character
  assign is_press = (key_value == VAL_PRESS) || (key_value == VAL_REPEAT);

  always_comb begin
    cmd.ch = CH_NONE;
    if (op == OP_POP) begin
      cmd.kind = CMD_POP;
    end else if (event_type == EV_KEY) begin
      cmd.kind = CMD_PUSH_KEY;
      if (is_press) begin
        cmd.ch = code_to_char(key_code);
      end
    end else begin
      cmd.kind = CMD_PUSH_OTHER;
    end
  end

endmodule

// ===== sv/kef_cmdq.sv =====
module kef_cmdq
  import kef_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_idx;
  logic [CMDQ_AW-1:0] rd_idx;
  logic [CMDQ_CW-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != CMDQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = slots[rd_idx];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Hold commands in order between front and back
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_idx] <= push_cmd;
        wr_idx <= (wr_idx == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_idx + 1'b1;
      end
      if (do_pop) begin
        rd_idx <= (rd_idx == CMDQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== sv/kef_back.sv =====
module kef_back
  import kef_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  cmd_t              cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              stored,
  output logic              dropped_full,
  output logic              had_event,
  output logic              char_valid,
  output logic [CHAR_W-1:0] char_out
);

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_t;

  state_t            state;
  logic [PTR_W-1:0]  wptr;
  logic [PTR_W-1:0]  rptr;
  logic [PTR_W-1:0]  wptr_next;
  logic [PTR_W-1:0]  rptr_next;
  logic              out_free;
  logic              take;
  logic              full;
  logic              empty;
  logic              ram_we;
  logic              ram_re;
  logic [CHAR_W-1:0] ram_rdata;

  // Ring pointer advance and occupancy
  assign wptr_next = (wptr == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : wptr + 1'b1;
  assign rptr_next = (rptr == PTR_W'(QUEUE_SLOTS - 1)) ? '0 : rptr + 1'b1;
  assign full      = (wptr_next == rptr);
  assign empty     = (wptr == rptr);

  // Take a command only when the result register can hold its outcome
  assign out_free  = !out_valid || out_ready;
  assign take      = (state == S_IDLE) && cmd_valid && out_free;
  assign cmd_ready = take;
  assign ram_we    = take && (cmd.kind == CMD_PUSH_KEY) && !full;
  assign ram_re    = take && (cmd.kind == CMD_POP) && !empty;

  kef_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (QUEUE_SLOTS)
  ) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wptr),
    .wdata (cmd.ch),
    .re    (ram_re),
    .raddr (rptr),
    .rdata (ram_rdata)
  );

  // Execute commands and load the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      wptr      <= '0;
      rptr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (take) begin
            stored       <= 1'b0;
            dropped_full <= 1'b0;
            had_event    <= 1'b0;
            char_valid   <= 1'b0;
            char_out     <= CH_NONE;
            case (cmd.kind)
              CMD_PUSH_KEY: begin
                out_valid    <= 1'b1;
                stored       <= !full;
                dropped_full <= full;
                if (!full) begin
                  wptr <= wptr_next;
                end
              end
              CMD_PUSH_OTHER: begin
                out_valid <= 1'b1;
              end
              CMD_POP: begin
                if (empty) begin
                  out_valid <= 1'b1;
                end else begin
                  rptr  <= rptr_next;
                  state <= S_READ;
                end
              end
              default: begin
                out_valid <= 1'b1;
              end
            endcase
          end
        end
        S_READ: begin
          out_valid  <= 1'b1;
          had_event  <= 1'b1;
          char_valid <= (ram_rdata != CH_NONE);
          char_out   <= ram_rdata;
          state      <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/kef_checker.sv =====
module kef_checker
  import kef_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input logic              stored,
  input logic              dropped_full,
  input logic              had_event,
  input logic              char_valid,
  input logic [CHAR_W-1:0] char_out
);

  logic [PTR_W:0] occ;

  // Track ring occupancy from delivered result beats
  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= '0;
    end else if (out_valid && out_ready) begin
      if (stored) begin
        occ <= occ + 1'b1;
      end else if (had_event) begin
        occ <= occ - 1'b1;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && had_event |-> occ != '0)
    else $error("event popped from an empty ring");

  a_store_room: assert property (@(posedge clk) disable iff (rst)
    out_valid && stored |-> occ != (PTR_W + 1)'(QUEUE_SLOTS - 1))
    else $error("event stored into a full ring");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    out_valid && dropped_full |-> occ == (PTR_W + 1)'(QUEUE_SLOTS - 1))
    else $error("event dropped while the ring had room");

  a_char_pop: assert property (@(posedge clk) disable iff (rst)
    out_valid && char_valid |-> had_event && char_out != CH_NONE)
    else $error("character reported without a popped event");

endmodule

bind key_event_fifo_with_ascii_map kef_checker u_kef_checker (.*);
